>>> rtl/core/lpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared types and constants for the line point generator: coordinate and
// error widths, the line kind code and the classified command record.
// ----------------------------------------------------------------------------
package lpg_pkg;

   localparam int COORD_BITS  = 6;
   // error term stays within about +/-(dx+dy); three extra bits cover it signed
   localparam int ERR_BITS    = COORD_BITS + 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef logic [COORD_BITS-1:0]      coord_type;
   typedef logic signed [ERR_BITS-1:0] err_type;

   typedef enum logic [1:0] {
      KIND_VERT  = 2'd0,
      KIND_HORIZ = 2'd1,
      KIND_DIAG  = 2'd2
   } kind_type;

   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
      coord_type dx;
      coord_type dy;
      logic      neg_x;
      logic      neg_y;
      kind_type  kind;
      coord_type steps;
      err_type   err0;
   } cmd_type;

   function automatic err_type widen(input coord_type v);
      return err_type'({{(ERR_BITS-COORD_BITS){1'b0}}, v});
   endfunction

endpackage

>>> rtl/core/lpg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpg_front
// Classifies a line command: deltas, step directions, line kind, step count
// and the starting error term.
// ----------------------------------------------------------------------------
module lpg_front (
   input  lpg_pkg::coord_type req_start_x,
   input  lpg_pkg::coord_type req_start_y,
   input  lpg_pkg::coord_type req_end_x,
   input  lpg_pkg::coord_type req_end_y,
   output lpg_pkg::cmd_type   cmd
);

   logic               x_up;
   logic               y_up;
   lpg_pkg::coord_type dx;
   lpg_pkg::coord_type dy;
   logic               x_major;

   always_comb begin
      x_up    = req_end_x > req_start_x;
      y_up    = req_end_y > req_start_y;
      dx      = x_up ? (req_end_x - req_start_x) : (req_start_x - req_end_x);
      dy      = y_up ? (req_end_y - req_start_y) : (req_start_y - req_end_y);
      x_major = dx > dy;

      cmd.start_x = req_start_x;
      cmd.start_y = req_start_y;
      cmd.end_x   = req_end_x;
      cmd.end_y   = req_end_y;
      cmd.dx      = dx;
      cmd.dy      = dy;
      cmd.neg_x   = !x_up;
      cmd.neg_y   = !y_up;
      cmd.steps   = x_major ? dx : dy;

      if (dx == '0) begin
         cmd.kind = lpg_pkg::KIND_VERT;
      end else if (dy == '0) begin
         cmd.kind = lpg_pkg::KIND_HORIZ;
      end else begin
         cmd.kind = lpg_pkg::KIND_DIAG;
      end

      // halving truncates toward zero on both signs
      if (x_major) begin
         cmd.err0 = lpg_pkg::widen(dx >> 1);
      end else begin
         cmd.err0 = -lpg_pkg::widen(dy >> 1);
      end
   end

endmodule

>>> rtl/core/lpg_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpg_cmd_queue
// Short register queue of classified commands between front and back.
// ----------------------------------------------------------------------------
module lpg_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lpg_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output lpg_pkg::cmd_type head
);

   lpg_pkg::cmd_type                 entry_ff [lpg_pkg::QUEUE_DEPTH];
   logic [lpg_pkg::QPTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [lpg_pkg::QPTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [lpg_pkg::QCNT_BITS-1:0]    count_ff, count_in;
   logic                             do_push;
   logic                             do_pop;

   assign full  = count_ff == lpg_pkg::QCNT_BITS'(lpg_pkg::QUEUE_DEPTH);
   assign valid = count_ff != '0;
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      do_push   = push && !full;
      do_pop    = pop && valid;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/core/lpg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpg_back
// Walks one command a pixel per cycle, pausing while the output register is
// held, and holds the oldest pixel in that register until it is popped.
// ----------------------------------------------------------------------------
module lpg_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  lpg_pkg::cmd_type   q_cmd,
   output logic               q_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output lpg_pkg::coord_type rsp_pixel_x,
   output lpg_pkg::coord_type rsp_pixel_y,
   output logic               rsp_last_pixel
);

   logic               busy_ff, busy_in;
   logic               out_valid_ff, out_valid_in;
   lpg_pkg::cmd_type   cmd_ff, cmd_in;
   lpg_pkg::coord_type x_ff, x_in;
   lpg_pkg::coord_type y_ff, y_in;
   lpg_pkg::err_type   err_ff, err_in;
   lpg_pkg::coord_type rem_ff, rem_in;
   lpg_pkg::coord_type px_ff, px_in;
   lpg_pkg::coord_type py_ff, py_in;
   logic               last_ff, last_in;

   logic               slot_free;
   logic               step_x;
   logic               step_y;
   lpg_pkg::err_type   err_mid;
   lpg_pkg::err_type   err_new;
   lpg_pkg::err_type   dx_e;
   lpg_pkg::err_type   dy_e;
   lpg_pkg::coord_type x_step;
   lpg_pkg::coord_type y_step;

   assign rsp_empty      = !out_valid_ff;
   assign rsp_pixel_x    = px_ff;
   assign rsp_pixel_y    = py_ff;
   assign rsp_last_pixel = last_ff;

   always_comb begin
      slot_free = !out_valid_ff || rsp_pop;
      q_pop     = slot_free && !busy_ff && q_valid;

      dx_e = lpg_pkg::widen(cmd_ff.dx);
      dy_e = lpg_pkg::widen(cmd_ff.dy);

      // second test sees the error already updated by the first
      step_x  = 1'b0;
      step_y  = 1'b0;
      err_mid = err_ff;
      err_new = err_ff;
      case (cmd_ff.kind)
         lpg_pkg::KIND_VERT:  step_y = 1'b1;
         lpg_pkg::KIND_HORIZ: step_x = 1'b1;
         default: begin
            step_x  = err_ff > -dx_e;
            err_mid = step_x ? err_ff - dy_e : err_ff;
            step_y  = err_mid < dy_e;
            err_new = step_y ? err_mid + dx_e : err_mid;
         end
      endcase

      x_step = cmd_ff.neg_x ? x_ff - 1'b1 : x_ff + 1'b1;
      y_step = cmd_ff.neg_y ? y_ff - 1'b1 : y_ff + 1'b1;

      busy_in      = busy_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      cmd_in       = cmd_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      err_in       = err_ff;
      rem_in       = rem_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      last_in      = last_ff;

      if (slot_free && busy_ff) begin
         out_valid_in = 1'b1;
         if (rem_ff == lpg_pkg::coord_type'(1)) begin
            // end point is emitted from the command, not from the walk
            px_in   = cmd_ff.end_x;
            py_in   = cmd_ff.end_y;
            last_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            x_in    = step_x ? x_step : x_ff;
            y_in    = step_y ? y_step : y_ff;
            err_in  = err_new;
            rem_in  = rem_ff - 1'b1;
            px_in   = step_x ? x_step : x_ff;
            py_in   = step_y ? y_step : y_ff;
            last_in = 1'b0;
         end
      end else if (q_pop) begin
         out_valid_in = 1'b1;
         cmd_in       = q_cmd;
         x_in         = q_cmd.start_x;
         y_in         = q_cmd.start_y;
         err_in       = q_cmd.err0;
         rem_in       = q_cmd.steps;
         busy_in      = q_cmd.steps != '0;
         px_in        = q_cmd.start_x;
         py_in        = q_cmd.start_y;
         last_in      = q_cmd.steps == '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      err_ff  <= err_in;
      rem_ff  <= rem_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      last_ff <= last_in;
   end

endmodule

>>> rtl/core/line_point_generator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_point_generator_core
// Bresenham-style pixel walker for lines inside a 64 by 64 tile.
// ----------------------------------------------------------------------------
// Usage:
//   Line commands come in on the req_ queue port: drive start and end
//   coordinates with req_push; the item is taken when req_full is low.
//   Pixels leave on the rsp_ queue port: while rsp_empty is low the oldest
//   pixel is on rsp_pixel_x / rsp_pixel_y / rsp_last_pixel, and rsp_pop
//   takes it. rsp_last_pixel marks the end point of each line.
//   A line gives max(|dx|, |dy|) + 1 pixels, one per cycle while the
//   receiver keeps popping; the pixel walker is the rate limit. Lines
//   follow each other with no gap when the next command is already queued.
//   A taken command is first written into the queue, and from there it is
//   loaded into the output register as its first pixel on the rsp_ ports
//   once the walker is idle and the output register is free.
//   Up to two classified commands wait in the queue behind the line being
//   walked; req_full goes high only when both slots are taken.
//   When the receiver holds off rsp_pop, the walk pauses with the pixel
//   kept; nothing is dropped.
//   Synchronous reset empties the queue and the output register; no other
//   state is kept between lines.
// ----------------------------------------------------------------------------
module line_point_generator_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  lpg_pkg::coord_type req_start_x,
   input  lpg_pkg::coord_type req_start_y,
   input  lpg_pkg::coord_type req_end_x,
   input  lpg_pkg::coord_type req_end_y,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output lpg_pkg::coord_type rsp_pixel_x,
   output lpg_pkg::coord_type rsp_pixel_y,
   output logic               rsp_last_pixel
);

   lpg_pkg::cmd_type front_cmd;
   lpg_pkg::cmd_type head_cmd;
   logic             head_valid;
   logic             head_pop;

   lpg_front u_front (
      .req_start_x (req_start_x),
      .req_start_y (req_start_y),
      .req_end_x   (req_end_x),
      .req_end_y   (req_end_y),
      .cmd         (front_cmd)
   );

   lpg_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .push_cmd (front_cmd),
      .full     (req_full),
      .pop      (head_pop),
      .valid    (head_valid),
      .head     (head_cmd)
   );

   lpg_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (head_valid),
      .q_cmd          (head_cmd),
      .q_pop          (head_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_last_pixel (rsp_last_pixel)
   );

endmodule
